// File: hdl/e8ra_pkg.sv
package e8ra_pkg;

  localparam int unsigned NumRegs  = 16;
  localparam int unsigned RegIdxW  = 4;
  localparam int unsigned DataW    = 8;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCountW  = 2;

  localparam logic [RegIdxW-1:0] FlagReg = 4'hF;

  // Top nibble of the instruction word.
  localparam logic [3:0] OpcLoad   = 4'h6;
  localparam logic [3:0] OpcAddImm = 4'h7;
  localparam logic [3:0] OpcAlu    = 4'h8;
  localparam logic [3:0] OpcRand   = 4'hC;

  // Low nibble of the ALU group.
  localparam logic [3:0] FnMove = 4'h0;
  localparam logic [3:0] FnOr   = 4'h1;
  localparam logic [3:0] FnAnd  = 4'h2;
  localparam logic [3:0] FnXor  = 4'h3;
  localparam logic [3:0] FnAdd  = 4'h4;
  localparam logic [3:0] FnSub  = 4'h5;
  localparam logic [3:0] FnShr  = 4'h6;
  localparam logic [3:0] FnSubn = 4'h7;
  localparam logic [3:0] FnShl  = 4'hE;

  typedef enum logic [3:0] {
    OP_IMM,
    OP_ADDI,
    OP_MOV,
    OP_OR,
    OP_AND,
    OP_XOR,
    OP_ADD,
    OP_SUB,
    OP_SHR,
    OP_SUBN,
    OP_SHL,
    OP_ILL
  } op_e;

  typedef struct packed {
    logic [15:0] instruction;
    logic [7:0]  rand_byte;
  } in_t;

  typedef struct packed {
    logic [3:0] dest_index;
    logic [7:0] dest_value;
    logic       flag_written;
    logic [7:0] flag_value;
    logic       illegal;
  } out_t;

  // Decoded instruction handed from the front to the back.
  typedef struct packed {
    op_e                op;
    logic [RegIdxW-1:0] x;
    logic [RegIdxW-1:0] y;
    logic [DataW-1:0]   imm;
  } uop_t;

  typedef struct packed {
    logic valid;
    uop_t uop;
  } uop_chan_t;

endpackage

// File: hdl/e8ra_ram.sv
module e8ra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hdl/e8ra_front.sv
module e8ra_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  e8ra_pkg::in_t       in_i,
  output e8ra_pkg::uop_chan_t uop_o,
  input  logic                uop_pop_i
);

  e8ra_pkg::uop_t                   dec_uop;
  e8ra_pkg::uop_t                   fifo_q [e8ra_pkg::QDepth];
  logic [e8ra_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [e8ra_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [e8ra_pkg::QCountW-1:0]     count_q, count_d;
  logic                             push;
  logic                             pop;

  always_comb begin
    dec_uop.x   = in_i.instruction[11:8];
    dec_uop.y   = in_i.instruction[7:4];
    dec_uop.imm = in_i.instruction[7:0];
    dec_uop.op  = e8ra_pkg::OP_ILL;
    unique case (in_i.instruction[15:12])
      e8ra_pkg::OpcLoad:   dec_uop.op = e8ra_pkg::OP_IMM;
      e8ra_pkg::OpcAddImm: dec_uop.op = e8ra_pkg::OP_ADDI;
      e8ra_pkg::OpcRand: begin
        // The random mask is applied here, so the back sees a plain load.
        dec_uop.op  = e8ra_pkg::OP_IMM;
        dec_uop.imm = in_i.instruction[7:0] & in_i.rand_byte;
      end
      e8ra_pkg::OpcAlu: begin
        unique case (in_i.instruction[3:0])
          e8ra_pkg::FnMove: dec_uop.op = e8ra_pkg::OP_MOV;
          e8ra_pkg::FnOr:   dec_uop.op = e8ra_pkg::OP_OR;
          e8ra_pkg::FnAnd:  dec_uop.op = e8ra_pkg::OP_AND;
          e8ra_pkg::FnXor:  dec_uop.op = e8ra_pkg::OP_XOR;
          e8ra_pkg::FnAdd:  dec_uop.op = e8ra_pkg::OP_ADD;
          e8ra_pkg::FnSub:  dec_uop.op = e8ra_pkg::OP_SUB;
          e8ra_pkg::FnShr:  dec_uop.op = e8ra_pkg::OP_SHR;
          e8ra_pkg::FnSubn: dec_uop.op = e8ra_pkg::OP_SUBN;
          e8ra_pkg::FnShl:  dec_uop.op = e8ra_pkg::OP_SHL;
          default:          dec_uop.op = e8ra_pkg::OP_ILL;
        endcase
      end
      default: dec_uop.op = e8ra_pkg::OP_ILL;
    endcase
  end

  assign in_stall_o = (count_q == e8ra_pkg::QCountW'(e8ra_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = uop_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec_uop;
    end
  end

  assign uop_o.valid = (count_q != '0);
  assign uop_o.uop   = fifo_q[rd_ptr_q];

endmodule

// File: hdl/e8ra_back.sv
module e8ra_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  e8ra_pkg::uop_chan_t uop_i,
  output logic                uop_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output e8ra_pkg::out_t      out_o
);

  localparam int unsigned RegIdxW = e8ra_pkg::RegIdxW;
  localparam int unsigned DataW   = e8ra_pkg::DataW;

  logic                    e_valid_q;
  e8ra_pkg::uop_t          e_uop_q;
  logic                    x_init_q, y_init_q;
  logic                    fwd_valid_q;
  logic [RegIdxW-1:0]      fwd_addr_q;
  logic [DataW-1:0]        fwd_data_q;
  logic [e8ra_pkg::NumRegs-1:0] written_q;
  logic [DataW-1:0]        vf_q, vf_d;
  logic                    out_valid_q;
  e8ra_pkg::out_t          out_q;

  logic [DataW-1:0] rdata_x, rdata_y;
  logic [DataW-1:0] vx, vy;
  logic [DataW:0]   sum;
  logic [DataW-1:0] res;
  logic             flag;
  logic             has_flag;
  logic             is_ill;
  logic             out_ready;
  logic             e_fire;
  logic             r_adv;
  logic             wr_en;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign e_fire    = e_valid_q && out_ready;
  assign r_adv     = uop_i.valid && (!e_valid_q || e_fire);
  assign uop_pop_o = r_adv;
  assign is_ill    = (e_uop_q.op == e8ra_pkg::OP_ILL);
  assign wr_en     = e_fire && !is_ill;

  e8ra_ram #(
    .Width(DataW),
    .Depth(e8ra_pkg::NumRegs)
  ) u_regs (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (e_uop_q.x),
    .wdata_i   (res),
    .re_i      (r_adv),
    .raddr_a_i (uop_i.uop.x),
    .raddr_b_i (uop_i.uop.y),
    .rdata_a_o (rdata_x),
    .rdata_b_o (rdata_y)
  );

  // Operand select: VF lives in its own register; the write that lands on the
  // same edge as the read is not in the read data and is forwarded instead.
  always_comb begin
    if (e_uop_q.x == e8ra_pkg::FlagReg) begin
      vx = vf_q;
    end else if (fwd_valid_q && (fwd_addr_q == e_uop_q.x)) begin
      vx = fwd_data_q;
    end else if (x_init_q) begin
      vx = rdata_x;
    end else begin
      vx = '0;
    end
    if (e_uop_q.y == e8ra_pkg::FlagReg) begin
      vy = vf_q;
    end else if (fwd_valid_q && (fwd_addr_q == e_uop_q.y)) begin
      vy = fwd_data_q;
    end else if (y_init_q) begin
      vy = rdata_y;
    end else begin
      vy = '0;
    end
  end

  always_comb begin
    sum      = {1'b0, vx} + {1'b0, vy};
    res      = '0;
    flag     = 1'b0;
    has_flag = 1'b0;
    unique case (e_uop_q.op)
      e8ra_pkg::OP_IMM:  res = e_uop_q.imm;
      e8ra_pkg::OP_ADDI: res = vx + e_uop_q.imm;
      e8ra_pkg::OP_MOV:  res = vy;
      e8ra_pkg::OP_OR:   res = vx | vy;
      e8ra_pkg::OP_AND:  res = vx & vy;
      e8ra_pkg::OP_XOR:  res = vx ^ vy;
      e8ra_pkg::OP_ADD: begin
        res      = sum[DataW-1:0];
        flag     = sum[DataW];
        has_flag = 1'b1;
      end
      e8ra_pkg::OP_SUB: begin
        res      = vx - vy;
        flag     = (vx > vy);
        has_flag = 1'b1;
      end
      e8ra_pkg::OP_SUBN: begin
        res      = vy - vx;
        flag     = (vy > vx);
        has_flag = 1'b1;
      end
      e8ra_pkg::OP_SHR: begin
        res      = {1'b0, vx[DataW-1:1]};
        flag     = vx[0];
        has_flag = 1'b1;
      end
      e8ra_pkg::OP_SHL: begin
        res      = {vx[DataW-2:0], 1'b0};
        flag     = vx[DataW-1];
        has_flag = 1'b1;
      end
      default: res = '0;
    endcase
  end

  // The destination write takes priority over the flag write, so it wins when x is VF.
  always_comb begin
    vf_d = vf_q;
    if (!is_ill) begin
      if (e_uop_q.x == e8ra_pkg::FlagReg) begin
        vf_d = res;
      end else if (has_flag) begin
        vf_d = {{(DataW-1){1'b0}}, flag};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      written_q   <= '0;
      vf_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (r_adv) begin
        e_valid_q   <= 1'b1;
        fwd_valid_q <= wr_en;
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
      end
      if (wr_en) begin
        written_q[e_uop_q.x] <= 1'b1;
      end
      if (e_fire) begin
        vf_q        <= vf_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_adv) begin
      e_uop_q    <= uop_i.uop;
      x_init_q   <= written_q[uop_i.uop.x];
      y_init_q   <= written_q[uop_i.uop.y];
      fwd_addr_q <= e_uop_q.x;
      fwd_data_q <= res;
    end
    if (e_fire) begin
      out_q.dest_index   <= is_ill ? '0 : e_uop_q.x;
      out_q.dest_value   <= is_ill ? '0 : res;
      out_q.flag_written <= !is_ill && has_flag;
      out_q.flag_value   <= vf_d;
      out_q.illegal      <= is_ill;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: hdl/eight_bit_regfile_alu.sv
// Channel  Valid        Stall         Payload
// input    in_valid_i   in_stall_o    in_i  (e8ra_pkg::in_t)
// output   out_valid_o  out_stall_i   out_o (e8ra_pkg::out_t)
//
// One instruction per cycle sustained while the output is not stalled. The input
// transfer writes the decode queue, the register file is read as the entry
// leaves the queue, and the execute stage writes the output register. The
// register file is a two-read, one-write RAM with registered reads; a write
// landing on the same edge as a read is forwarded.
// Reset clears all sixteen registers at once through per-entry written bits.
// A stall at the output fills the two-entry queue before the input stalls.
module eight_bit_regfile_alu (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  e8ra_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output e8ra_pkg::out_t out_o
);

  e8ra_pkg::uop_chan_t uop;
  logic                uop_pop;

  e8ra_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .uop_o      (uop),
    .uop_pop_i  (uop_pop)
  );

  e8ra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_i       (uop),
    .uop_pop_o   (uop_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
